FILE: rtl/ebp_pkg.sv
// ============================================================================
// ebp_pkg
// Shared types and constants for the exhaustive bin packing core.
// ============================================================================
package ebp_pkg;

    localparam int WEIGHT_W = 16;
    localparam int CAP_W    = 20;
    localparam int CNT_W    = 4;
    localparam int SUM_W    = 21;

    localparam logic CFG_ITEM_COUNT   = 1'b0;
    localparam logic CFG_BIN_CAPACITY = 1'b1;

    // Per-cell view of one search step; every cell sees the same broadcast.
    typedef struct packed {
        logic             clear;     // start of a search: reset sums
        logic             add;       // place item weight into selected bin
        logic             sub;       // remove item weight from selected bin
        logic [CNT_W-1:0] bin;       // 0-based bin number
        logic [WEIGHT_W-1:0] w;      // weight being placed or removed
    } ebp_cmd_t;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_TRY   = 5'b00010,
        ST_BACK  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_START = 5'b10000
    } ebp_state_t;

endpackage

FILE: rtl/ebp_bin_cell.sv
// ============================================================================
// ebp_bin_cell
// One bin of the packing row: holds the bin's weight sum and member count.
// ============================================================================
module ebp_bin_cell #(
    parameter logic [3:0] BIN_ID = 4'd0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ebp_pkg::ebp_cmd_t     cmd,
    output logic [ebp_pkg::SUM_W-1:0] sum,
    output logic                  empty
);
    import ebp_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] mem_reg, mem_next;
    logic             hit;

    assign hit = (cmd.bin == BIN_ID);

    always_comb
    begin
        sum_next = sum_reg;
        mem_next = mem_reg;
        if (cmd.clear)
        begin
            sum_next = '0;
            mem_next = '0;
        end
        else if (hit && cmd.add)
        begin
            sum_next = sum_reg + SUM_W'(cmd.w);
            mem_next = mem_reg + 1'b1;
        end
        else if (hit && cmd.sub)
        begin
            sum_next = sum_reg - SUM_W'(cmd.w);
            mem_next = mem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            mem_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            mem_reg <= mem_next;
        end
    end

    assign sum   = sum_reg;
    assign empty = (mem_reg == '0);

    a_add_sub_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.add && cmd.sub)) else $error("add and sub together");
    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_reg == '0) |-> (sum_reg == '0)) else $error("empty bin with weight");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (mem_reg == '0)) else $error("clear failed");
endmodule

FILE: rtl/exhaustive_bin_packing_core.sv
// ============================================================================
// exhaustive_bin_packing_core
// Loads weights, runs a depth-first bin packing search over a row of bin
// cells, and streams out the best assignment.
// ============================================================================
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | weight
// out     | out | out_valid / out_stall| bin_index, bins_used, last_item
// cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// Weights load one per cycle. After the last weight, ST_START clears the bin
// cells, then each search cycle does one step: try one candidate bin (place
// or skip it), close an exhausted level, record a leaf, or undo one item.
// Results then leave one per cycle when out_stall is low, held while it is
// high. Input stalls from the last weight until the final result is taken.
// Reset returns control to LOAD with default item count and capacity; bin cells reset to empty.
module exhaustive_bin_packing_core #(
    parameter int MAX_ITEMS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] weight,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  bin_index,
    output logic [3:0]  bins_used,
    output logic        last_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);
    import ebp_pkg::*;

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [CNT_W-1:0]    item_count_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [WEIGHT_W-1:0] wst_reg [MAX_ITEMS];
    logic [CNT_W-1:0]    trial_reg [MAX_ITEMS];
    logic [CNT_W-1:0]    best_reg [MAX_ITEMS];
    logic [CNT_W:0]      best_cnt_reg;
    logic [CNT_W:0]      open_reg;
    logic [CNT_W:0]      k_reg;       // current depth
    logic [CNT_W:0]      n_reg;
    logic [CNT_W:0]      ld_reg;
    logic                found_reg;
    ebp_state_t          st_reg;

    logic [SUM_W-1:0]    sums  [MAX_ITEMS];
    logic                empt  [MAX_ITEMS];
    ebp_cmd_t            cmd;

    logic [CNT_W:0] eff_n;
    always_comb
    begin
        if (item_count_reg == '0)
            eff_n = 5'd1;
        else if (32'(item_count_reg) > MAX_ITEMS)
            eff_n = (CNT_W+1)'(MAX_ITEMS);
        else
            eff_n = {1'b0, item_count_reg};
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++)
        begin : g_cell
            ebp_bin_cell #(.BIN_ID(4'(g))) u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd),
                .sum(sums[g]), .empty(empt[g]));
        end
    endgenerate

    // Candidate at current depth: trial bin j (1-based) from trial_reg[k].
    logic [IW-1:0]       kix;
    logic [CNT_W-1:0]    cand;
    logic [IW-1:0]       bix;
    logic [SUM_W-1:0]    tot;
    logic                fits, beats, cand_ok, cand_end;
    logic [CNT_W:0]      opens;
    assign kix   = k_reg[IW-1:0];
    assign cand  = trial_reg[kix];
    assign bix   = IW'(cand - 1'b1);
    assign opens = {4'd0, empt[bix]};
    assign tot   = sums[bix] + SUM_W'(wst_reg[kix]);
    assign fits  = (tot <= SUM_W'(cap_reg));
    assign beats = ((open_reg + opens) < best_cnt_reg);
    assign cand_end = ({1'b0, cand} > k_reg + 1'b1);
    assign cand_ok  = fits && beats;

    // Undo target at depth k-1.
    logic [IW-1:0] pix;
    assign pix = IW'(k_reg - 1'b1);

    logic in_acc, out_acc;
    assign in_stall  = (st_reg != ST_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (st_reg == ST_EMIT);
    assign out_acc   = out_valid && !out_stall;
    assign bin_index = found_reg ? best_reg[kix] : '0;
    assign bins_used = found_reg ? best_cnt_reg[CNT_W-1:0] : '0;
    assign last_item = (k_reg + 1'b1 == n_reg);

    // Bin of item p becomes empty on undo when no earlier item shares it.
    function automatic logic empt_after(input logic [IW-1:0] p);
        logic r;
        r = 1'b1;
        for (int i = 0; i < MAX_ITEMS; i++)
            if (i < int'(p) && trial_reg[i] == trial_reg[p])
                r = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        cmd = '0;
        cmd.bin = 4'(bix);
        cmd.w   = wst_reg[kix];
        unique case (st_reg)
            ST_START: cmd.clear = 1'b1;
            ST_TRY:
            begin
                if (k_reg < n_reg && !cand_end && cand_ok)
                    cmd.add = 1'b1;
            end
            ST_BACK:
            begin
                cmd.bin = trial_reg[pix] - 1'b1;
                cmd.w   = wst_reg[pix];
                cmd.sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && ld_reg < (CNT_W+1)'(MAX_ITEMS))
            wst_reg[ld_reg[IW-1:0]] <= weight;
        if (st_reg == ST_TRY && k_reg >= n_reg && open_reg < best_cnt_reg)
            for (int i = 0; i < MAX_ITEMS; i++)
                best_reg[i] <= trial_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= 4'd12;
            cap_reg        <= 20'd65536;
            st_reg         <= ST_LOAD;
            ld_reg         <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            open_reg       <= '0;
            best_cnt_reg   <= '0;
            found_reg      <= 1'b0;
            for (int i = 0; i < MAX_ITEMS; i++)
                trial_reg[i] <= 4'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ITEM_COUNT)
                    item_count_reg <= cfg_data[CNT_W-1:0];
                else
                    cap_reg <= cfg_data;
            end
            unique case (st_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (ld_reg + 1'b1 >= eff_n)
                        begin
                            ld_reg       <= '0;
                            n_reg        <= eff_n;
                            best_cnt_reg <= eff_n + 1'b1;
                            open_reg     <= '0;
                            found_reg    <= 1'b0;
                            k_reg        <= '0;
                            for (int i = 0; i < MAX_ITEMS; i++)
                                trial_reg[i] <= 4'd1;
                            st_reg <= ST_START;
                        end
                        else
                            ld_reg <= ld_reg + 1'b1;
                    end
                end
                ST_START: st_reg <= ST_TRY;
                ST_TRY:
                begin
                    if (k_reg >= n_reg)
                    begin
                        // leaf: record if it beats the best, then back up
                        if (open_reg < best_cnt_reg)
                        begin
                            best_cnt_reg <= open_reg;
                            found_reg    <= 1'b1;
                        end
                        st_reg <= ST_BACK;
                    end
                    else if (cand_end)
                    begin
                        trial_reg[kix] <= 4'd1;
                        if (k_reg == '0)
                        begin
                            k_reg  <= '0;
                            st_reg <= ST_EMIT;
                        end
                        else
                            st_reg <= ST_BACK;
                    end
                    else if (cand_ok)
                    begin
                        open_reg <= open_reg + opens;
                        k_reg    <= k_reg + 1'b1;
                    end
                    else
                        trial_reg[kix] <= cand + 1'b1;
                end
                ST_BACK:
                begin
                    // undo item k-1 and advance its choice
                    open_reg <= open_reg - {4'd0,
                        (sums[trial_reg[pix][IW-1:0] - 1'b1] == SUM_W'(wst_reg[pix]))
                        && empt_after(pix)};
                    trial_reg[pix] <= trial_reg[pix] + 1'b1;
                    k_reg  <= k_reg - 1'b1;
                    st_reg <= ST_TRY;
                end
                ST_EMIT:
                begin
                    if (out_acc)
                    begin
                        if (k_reg + 1'b1 == n_reg)
                        begin
                            k_reg  <= '0;
                            st_reg <= ST_LOAD;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                default: st_reg <= ST_LOAD;
            endcase
        end
    end

    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_LOAD) |-> in_stall) else $error("input open during search");
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_TRY) |-> (k_reg <= n_reg)) else $error("depth overrun");
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_TRY) |-> (open_reg <= k_reg)) else $error("open count too big");
    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found_reg) |-> (bins_used != '0)) else $error("zero bins");
endmodule
